FILE: sv/pcict_pkg.sv
package pcict_pkg;

    // Service and function codes
    localparam logic [7:0] SVC_PCI        = 8'hB1;
    localparam logic [7:0] FN_READ_BYTE   = 8'h08;
    localparam logic [7:0] FN_READ_WORD   = 8'h09;
    localparam logic [7:0] FN_READ_DWORD  = 8'h0A;
    localparam logic [7:0] FN_WRITE_BYTE  = 8'h0B;
    localparam logic [7:0] FN_WRITE_WORD  = 8'h0C;
    localparam logic [7:0] FN_WRITE_DWORD = 8'h0D;

    // Access mechanism codes
    localparam logic [1:0] MECH_BIOS = 2'd0;
    localparam logic [1:0] MECH_ONE  = 2'd1;
    localparam logic [1:0] MECH_TWO  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IDX_MECH = 1'b0;
    localparam logic CFG_IDX_MASK = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 32;

    localparam logic [31:0] M1_ENABLE   = 32'h8000_0000;
    localparam logic [3:0]  M2_BASE_HI  = 4'hC;
    localparam logic [7:0]  M2_EN_BASE  = 8'h01;
    localparam logic [7:0]  M2_EN_TYPE1 = 8'h80;

    typedef struct packed {
        logic [7:0]  service_class;
        logic [7:0]  action;
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [7:0]  register_offset;
        logic [15:0] cx_in;
        logic [15:0] dx_in;
        logic [31:0] config_dword_in;
    } t_req;

    typedef struct packed {
        logic        handled;
        logic        carry_flag;
        logic [15:0] cx_out;
        logic [15:0] dx_out;
        logic [31:0] cycle_address;
        logic [7:0]  mech2_enable;
        logic [7:0]  mech2_forward;
        logic        write_strobe;
        logic [31:0] write_dword;
        logic [3:0]  lane_mask;
        logic [31:0] call_count;
        logic [31:0] fallback_count;
    } t_rsp;

    // Counting events of one request
    typedef struct packed {
        logic req;
        logic hit;
    } t_flags;

endpackage

FILE: sv/pcict_req_if.sv
interface pcict_req_if
    import pcict_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pcict_rsp_if.sv
interface pcict_rsp_if
    import pcict_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pci_config_request_translator.sv
// PCI configuration request translator. Takes one BIOS-style configuration
// request per beat on i_req and returns one result per beat on o_rsp. The block
// is a two-register pipeline (input register, then result register) with the
// decode, address build, lane extract and merge, and counter increments between
// them. It accepts one request every cycle while o_rsp.ready stays high.
// o_rsp.valid rises once the request moves from the input register into the
// result register. A waiting result holds the input stage only once the input
// register is full as well, so two requests are held before i_req.ready drops.
// Configuration writes on i_cfg_we are taken at any time but must be made while
// no request is in flight; index 0 selects the access mechanism, index 1 the
// function mask.
module pci_config_request_translator
    import pcict_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcict_req_if.sink             i_req,
    pcict_rsp_if.source           o_rsp
);

    logic [1:0]  r_mech;
    logic [15:0] r_mask;

    logic   r_a_valid;
    t_req   r_a_data;
    logic   r_b_valid;
    t_rsp   r_b_data;

    logic   adv_a;
    logic   adv_b;
    t_flags flags;
    t_rsp   xlate_rsp;
    t_rsp   n_rsp;
    logic [COUNT_W-1:0] calls;
    logic [COUNT_W-1:0] fallbacks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mech <= MECH_BIOS;
            r_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_MECH: r_mech <= i_cfg_data[1:0];
                CFG_IDX_MASK: r_mask <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    assign adv_b       = r_a_valid && (!r_b_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || adv_b;
    assign adv_a       = i_req.valid && i_req.ready;

    pcict_xlate u_xlate (
        .i_req   (r_a_data),
        .i_mech  (r_mech),
        .i_mask  (r_mask),
        .o_flags (flags),
        .o_rsp   (xlate_rsp)
    );

    pcict_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv_b),
        .i_flags     (flags),
        .o_calls     (calls),
        .o_fallbacks (fallbacks)
    );

    always_comb begin
        n_rsp                = xlate_rsp;
        n_rsp.call_count     = calls;
        n_rsp.fallback_count = fallbacks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (adv_a)                  r_a_valid <= 1'b1;
            else if (adv_b)             r_a_valid <= 1'b0;
            if (adv_b)                  r_b_valid <= 1'b1;
            else if (o_rsp.ready)       r_b_valid <= 1'b0;
        end
    end

    // Payload stages: hold unless a beat moves in
    always_ff @(posedge i_clk) begin
        if (adv_a) r_a_data <= i_req.data;
        if (adv_b) r_b_data <= n_rsp;
    end

    assign o_rsp.valid = r_b_valid;
    assign o_rsp.data  = r_b_data;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_a_valid && !r_b_valid)
        else $error("pipeline not empty after reset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !o_rsp.ready |-> !adv_b)
        else $error("result overwritten while stalled");

    a_passed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !r_b_data.handled |->
            !r_b_data.carry_flag && !r_b_data.write_strobe && r_b_data.lane_mask == 4'h0)
        else $error("passed-on result carries access fields");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_data.carry_flag |->
            !r_b_data.write_strobe && r_b_data.cycle_address == 32'h0)
        else $error("failed request issued an access");

endmodule

FILE: sv/pcict_xlate.sv
module pcict_xlate
    import pcict_pkg::*;
(
    input  t_req        i_req,
    input  logic [1:0]  i_mech,
    input  logic [15:0] i_mask,
    output t_flags      o_flags,
    output t_rsp        o_rsp
);

    logic        is_req;
    logic        hit;
    logic        is_write;
    logic        sz_byte;
    logic        sz_word;
    logic        ok;
    logic [4:0]  sh;
    logic [31:0] fmask;
    logic [1:0]  port_lo;
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic [7:0]  off;

    assign off    = i_req.register_offset;
    assign is_req = (i_req.service_class == SVC_PCI) &&
                    (i_req.action >= FN_READ_BYTE) && (i_req.action <= FN_WRITE_DWORD);
    assign hit    = is_req && i_mask[i_req.action[3:0]];

    assign o_flags.req = is_req;
    assign o_flags.hit = hit;

    always_comb begin
        sz_byte  = 1'b0;
        sz_word  = 1'b0;
        is_write = 1'b0;
        case (i_req.action)
            FN_READ_BYTE:   sz_byte = 1'b1;
            FN_READ_WORD:   sz_word = 1'b1;
            FN_WRITE_BYTE:  begin sz_byte = 1'b1; is_write = 1'b1; end
            FN_WRITE_WORD:  begin sz_word = 1'b1; is_write = 1'b1; end
            FN_WRITE_DWORD: is_write = 1'b1;
            default:        ;
        endcase
    end

    always_comb begin
        ok = (i_mech == MECH_ONE) || (i_mech == MECH_TWO);
        if (sz_word && off[0]) ok = 1'b0;
        if (!sz_byte && !sz_word && (off[1:0] != 2'b00)) ok = 1'b0;
        if ((i_mech == MECH_TWO) && i_req.device_number[4]) ok = 1'b0;
    end

    always_comb begin
        if (sz_byte) begin
            sh      = {off[1:0], 3'b000};
            fmask   = 32'h0000_00FF;
            port_lo = off[1:0];
        end else if (sz_word) begin
            sh      = {off[1], 4'b0000};
            fmask   = 32'h0000_FFFF;
            port_lo = {off[1], 1'b0};
        end else begin
            sh      = 5'd0;
            fmask   = 32'hFFFF_FFFF;
            port_lo = 2'b00;
        end
    end

    assign wdata = {i_req.dx_in, i_req.cx_in};
    assign rdata = (i_req.config_dword_in >> sh) & fmask;

    always_comb begin
        o_rsp                = '0;
        o_rsp.cx_out         = i_req.cx_in;
        o_rsp.dx_out         = i_req.dx_in;
        o_rsp.call_count     = '0;
        o_rsp.fallback_count = '0;
        if (hit) begin
            o_rsp.handled = 1'b1;
            if (!ok) begin
                o_rsp.carry_flag = 1'b1;
            end else begin
                if (sz_byte)      o_rsp.lane_mask = 4'b0001 << off[1:0];
                else if (sz_word) o_rsp.lane_mask = 4'b0011 << {off[1], 1'b0};
                else              o_rsp.lane_mask = 4'b1111;

                if (i_mech == MECH_ONE) begin
                    o_rsp.cycle_address = M1_ENABLE |
                        {8'h00, i_req.bus_number, i_req.device_number,
                         i_req.function_number, off[7:2], 2'b00};
                end else begin
                    o_rsp.cycle_address = {16'h0000, M2_BASE_HI,
                        i_req.device_number[3:0], off[7:2], port_lo};
                    o_rsp.mech2_enable  = M2_EN_BASE | {4'h0, i_req.function_number, 1'b0} |
                        ((i_req.bus_number != 8'h00) ? M2_EN_TYPE1 : 8'h00);
                    o_rsp.mech2_forward = i_req.bus_number;
                end

                if (is_write) begin
                    o_rsp.write_strobe = 1'b1;
                    o_rsp.write_dword  = (i_req.config_dword_in & ~(fmask << sh)) |
                                         ((wdata & fmask) << sh);
                end else if (sz_byte) begin
                    o_rsp.cx_out = {i_req.cx_in[15:8], rdata[7:0]};
                end else if (sz_word) begin
                    o_rsp.cx_out = rdata[15:0];
                end else begin
                    o_rsp.cx_out = rdata[15:0];
                    o_rsp.dx_out = rdata[31:16];
                end
            end
        end
    end

endmodule

FILE: sv/pcict_stats.sv
module pcict_stats
    import pcict_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_flags             i_flags,
    output logic [COUNT_W-1:0] o_calls,
    output logic [COUNT_W-1:0] o_fallbacks
);

    logic [COUNT_W-1:0] r_calls;
    logic [COUNT_W-1:0] r_fallbacks;

    // Counts after the request now leaving the input stage
    assign o_calls     = r_calls + COUNT_W'(i_flags.req);
    assign o_fallbacks = r_fallbacks + COUNT_W'(i_flags.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calls     <= '0;
            r_fallbacks <= '0;
        end else if (i_adv) begin
            r_calls     <= o_calls;
            r_fallbacks <= o_fallbacks;
        end
    end

    a_hit_is_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flags.hit |-> i_flags.req)
        else $error("fallback counted for a non-request");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_calls) && $stable(r_fallbacks))
        else $error("counters moved without a beat");

    a_fb_le_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_flags.req |=> $stable(r_calls) && $stable(r_fallbacks))
        else $error("counters moved on a passed-on beat");

endmodule
